// ===== rtl/rat_pkg.sv =====
// ----------------------------------------------------------------------------
// rat_pkg
// Types and constants shared by the rotation angle tracker.
// ----------------------------------------------------------------------------
package rat_pkg;

  localparam logic [31:0] WinLo     = 32'd10000;
  localparam logic [31:0] WinHi     = 32'd10000000;
  localparam logic [31:0] StopLimit = 32'd1000000;
  localparam logic [31:0] StepReset = 32'd256;
  localparam logic [26:0] PerReset  = 27'd67108864;
  localparam logic [26:0] PerMin    = 27'd10000;
  localparam logic [31:0] DegScale  = 32'd11930464;

  localparam logic RegLock  = 1'b0;
  localparam logic RegDrift = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_DIV,
    ST_LOCK,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [26:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [32:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/rotation_angle_tracker_core.sv =====
// ----------------------------------------------------------------------------
// rotation_angle_tracker_core
// Shaft angle tracker from a half-turn sync pin and a microsecond timer.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A beat without an accepted sync edge shows its
// result after two 32x32 multiplies on one shared multiplier, then the output
// load. A beat with an accepted edge adds a median pass (one count-compare per
// cycle), a bit-serial divide (start, 33 quotient bits, finish) and a lock
// step. The input is not ready while a beat is in work or its result waits in
// the output register.
module rotation_angle_tracker_core #(
  parameter int HISTORY_DEPTH = 8,
  parameter int ZERO_DEGREES  = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // tick_now[31:0], sync_in[32], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // angle_out[31:0], stopped[32],
                                     // period_smoothed[59:33], period_raw[91:60]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import rat_pkg::*;

  localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW-1:0] KLo = CW'((HISTORY_DEPTH - 1) / 2);
  localparam logic [CW-1:0] KHi = CW'(HISTORY_DEPTH / 2);
  localparam logic [IW-1:0] LastSlot = IW'(HISTORY_DEPTH - 1);

  state_e state_q, state_d;

  logic        lock_q;
  logic [31:0] drift_q;
  logic [31:0] edge_q, tick_q, phase_q, step_q, zoff_q, rawp_q;
  logic [26:0] smp_q;
  logic [IW-1:0] slot_q;
  logic        psync_q;
  logic [31:0] ring_q [HISTORY_DEPTH];

  logic [31:0] now_q, el_q, dt_q;
  logic        sync_q;
  logic [IW-1:0] oi_q, ii_q;
  logic [CW-1:0] lt_q;
  logic [31:0] lo_q, hi_q;
  logic        ph_q;
  logic [95:0] out_q;
  logic        ov_q;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [31:0] now_w, el_w;
  logic        sync_w, edge_w, acc_w, take;
  logic [31:0] cand, other;
  logic [32:0] msum;
  logic [26:0] mper;
  logic [31:0] rate, x, err, lim, nrate;
  logic [31:0] mul_a, mul_b, prod;

  assign now_w  = s_axis_tdata[31:0];
  assign sync_w = s_axis_tdata[32];
  assign el_w   = now_w - edge_q;
  assign edge_w = sync_w != psync_q;
  assign acc_w  = edge_w && el_w > WinLo && el_w < WinHi;
  assign s_axis_tready = state_q == ST_IDLE && !ov_q;
  assign take   = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  assign cand  = ring_q[oi_q];
  assign other = ring_q[ii_q];
  assign msum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mper  = (msum < {6'd0, PerMin}) ? PerMin : msum[26:0];

  assign rate  = drsp.quotient[31:0];
  assign x     = phase_q + (sync_q ? 32'd0 : 32'h80000000);
  assign err   = $signed(x ^ 32'h80000000) >>> 17;
  assign lim   = $signed(rate) / 32'sd16;
  always_comb begin
    nrate = rate;
    if (lock_q) begin
      if ($signed(err) > $signed(lim)) nrate = rate - lim;
      else if ($signed(err) < -$signed(lim)) nrate = rate + lim;
      else nrate = rate - err;
    end
  end

  assign mul_a = dt_q;
  assign mul_b = ph_q ? drift_q : step_q;
  assign prod  = mul_a * mul_b;

  always_comb begin
    dreq.start    = (state_q == ST_DIV) && !drsp.busy && !drsp.done;
    dreq.dividend = 33'h100000000;
    dreq.divisor  = mper;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take) state_d = acc_w ? ST_SORT : ST_MUL;
      ST_SORT: if (oi_q == LastSlot && ii_q == LastSlot) state_d = ST_DIV;
      ST_DIV:  if (drsp.done) state_d = ST_LOCK;
      ST_LOCK: state_d = ST_MUL;
      ST_MUL:  if (ph_q) state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  rat_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic cnt_lt, last_i;
  logic [CW-1:0] lt_n;
  assign cnt_lt = (other < cand) || (other == cand && ii_q < oi_q);
  assign lt_n   = lt_q + CW'(cnt_lt);
  assign last_i = ii_q == LastSlot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lock_q  <= 1'b1;
      drift_q <= '0;
      edge_q  <= '0;
      tick_q  <= '0;
      phase_q <= '0;
      step_q  <= StepReset;
      zoff_q  <= DegScale * 32'(ZERO_DEGREES);
      rawp_q  <= '0;
      smp_q   <= PerReset;
      slot_q  <= '0;
      psync_q <= 1'b0;
      ov_q    <= 1'b0;
      ph_q    <= 1'b0;
      oi_q    <= '0;
      ii_q    <= '0;
      lt_q    <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) ring_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegLock) lock_q <= cfg_wdata_i[0];
        else drift_q <= cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (take) begin
          ph_q <= 1'b0;
          oi_q <= '0;
          ii_q <= '0;
          lt_q <= '0;
          if (edge_w) begin
            psync_q <= sync_w;
            edge_q  <= now_w;
            rawp_q  <= {el_w[30:0], 1'b0};
          end
          if (acc_w) begin
            if (slot_q == LastSlot) begin
              slot_q <= '0;
              ring_q[0] <= el_w;
            end else begin
              slot_q <= slot_q + IW'(1);
              ring_q[slot_q + IW'(1)] <= el_w;
            end
          end
        end
        ST_SORT: begin
          if (last_i) begin
            if (((ii_q != oi_q) ? lt_n : lt_q) == KLo) lo_q <= cand;
            if (((ii_q != oi_q) ? lt_n : lt_q) == KHi) hi_q <= cand;
            lt_q <= '0;
            ii_q <= '0;
            oi_q <= oi_q + IW'(1);
          end else begin
            if (ii_q != oi_q) lt_q <= lt_n;
            ii_q <= ii_q + IW'(1);
          end
        end
        ST_DIV: if (dreq.start) smp_q <= mper;
        ST_LOCK: step_q <= nrate;
        ST_MUL: begin
          ph_q <= 1'b1;
          if (!ph_q) phase_q <= phase_q + prod;
          else zoff_q <= zoff_q + prod;
        end
        ST_OUT: begin
          tick_q <= now_q;
          ov_q   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      now_q  <= now_w;
      el_q   <= el_w;
      sync_q <= sync_w;
      dt_q   <= now_w - tick_q;
    end
    if (state_q == ST_OUT)
      out_q <= {4'd0, rawp_q, smp_q, el_q > StopLimit, phase_q + zoff_q};
  end

  logic unused;
  assign unused = drsp.quotient[32] ^ s_axis_tdata[33] ^ (|s_axis_tdata[39:34]);

endmodule

// ===== rtl/rat_div.sv =====
// ----------------------------------------------------------------------------
// rat_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rat_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rat_pkg::div_req_t req_i,
  output rat_pkg::div_rsp_t rsp_o
);
  import rat_pkg::*;

  logic [32:0] quo_q, quo_d;
  logic [27:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [26:0] dvs_q, dvs_d;
  logic [27:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    trial  = {rem_q[26:0], quo_q[32]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'd33;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/rat_checker.sv =====
// ----------------------------------------------------------------------------
// rat_checker
// Port-level checks for the rotation angle tracker.
// ----------------------------------------------------------------------------
module rat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped");
  a_noin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result held");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("back to back take");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[95:92] == 4'd0) else $error("fill bits set");
endmodule

bind rotation_angle_tracker_core rat_checker u_chk (.*);
